### rtl/bmnc_pkg.sv
package bmnc_pkg;

    // Longest supported row and tallest supported frame.
    localparam int MAX_LINE = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int MIN_DIM  = 3;

    // Column index into a line store, and the width of size registers.
    localparam int COL_W = $clog2(MAX_LINE);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int DIM_W = 11;
    localparam int THR_W = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NBR_THRESH   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [THR_W-1:0] RST_NBR_THRESH   = 4'd4;

    // Input item command codes.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic command;
        logic mask_bit;
    } t_in_item;

    typedef struct packed {
        logic filtered_bit;
        logic end_of_frame;
    } t_out_item;

endpackage

### rtl/binary_mask_neighbour_count_filter_core.sv
// Binary 3x3 neighbour-count filter for a raster-order mask stream. Each input beat carries one
// mask pixel (command 0) or a flush tick (command 1); the block can take one beat in every clock
// cycle and gives at most one result per input beat, in the cycle after the beat that releases
// it, so it sustains one pixel per cycle. Results leave in raster order frame_width+1 pixel
// positions behind the input: an interior pixel becomes 1 when at least the programmed neighbour
// threshold of its eight neighbours in the original mask are set, and a border pixel passes
// through unchanged. Consecutive frames form one stream, so the next frame's pixels push out the
// previous frame's tail; at the end of the last frame, flush beats release that tail one pixel
// each, the last one flagged end_of_frame. A flush that arrives mid-frame or with nothing
// pending is taken and ignored. The two line stores share one 1024 x 2 bit memory whose read
// data is registered, so the input stalls during a configuration write and in the cycle after it,
// and in the cycle after reset, while the read data is refetched for the new frame size.
// The input also stalls while a result waits in the output register under a receiver stall.
module binary_mask_neighbour_count_filter_core
    import bmnc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    // Configuration registers.
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [THR_W-1:0] r_nbr_thresh;
    logic             r_cfg_hold;

    // Stream position, window and count of positions not yet given out.
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_pend, n_pend;
    logic [8:0]       r_win, n_win;

    // Line store memory: bit 1 holds the upper row, bit 0 the middle row.
    logic [1:0]       r_line_mem [MAX_LINE];
    logic [1:0]       r_rd_pix;
    logic [1:0]       r_rd_flush;

    logic             r_out_valid;
    t_out_item        r_out_data;

    // Sizes clamped to their legal range.
    logic [DIM_W-1:0] w_eff, h_eff, w_p1;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [DIM_W-1:0] pend_eff;

    logic             in_acc, is_flush, flush_ok, pend_full, emit;
    logic             bit_up, bit_mid;
    logic [3:0]       count;
    logic [DIM_W-1:0] tr, tc, col_x, row_x, k_x;
    logic             interior, val_pix, eof_pix, val_out, eof_out;
    logic             mem_we;
    logic [COL_W-1:0] rd_addr_pix, rd_addr_flush;
    logic [DIM_W-1:0] pend_look, flush_diff;

    always_comb begin
        if (r_frame_width < DIM_W'(MIN_DIM)) begin
            w_eff = DIM_W'(MIN_DIM);
        end else if (r_frame_width > DIM_W'(MAX_LINE)) begin
            w_eff = DIM_W'(MAX_LINE);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < DIM_W'(MIN_DIM)) begin
            h_eff = DIM_W'(MIN_DIM);
        end else if (r_frame_height > DIM_W'(MAX_ROWS)) begin
            h_eff = DIM_W'(MAX_ROWS);
        end else begin
            h_eff = r_frame_height;
        end
        w_p1 = w_eff + DIM_W'(1);
    end

    // A counter left beyond a smaller frame restarts at zero, and the pending count is limited
    // to one row plus one pixel.
    assign col_eff  = (DIM_W'(r_col) >= w_eff) ? '0 : r_col;
    assign row_eff  = (DIM_W'(r_row) >= h_eff) ? '0 : r_row;
    assign pend_eff = (r_pend > w_p1) ? w_p1 : r_pend;

    assign o_in_stall = i_cfg_we | r_cfg_hold | (r_out_valid & i_out_stall);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign is_flush   = (i_in_data.command == CMD_FLUSH);
    assign pend_full  = (pend_eff == w_p1);
    assign flush_ok   = (col_eff == '0) && (row_eff == '0) && (pend_eff != '0);

    assign bit_up  = r_rd_pix[1];
    assign bit_mid = r_rd_pix[0];

    // Shift the window one column: the newest column enters at the top bit of each row.
    assign n_win = {i_in_data.mask_bit, r_win[8:7],
                    bit_mid,            r_win[5:4],
                    bit_up,             r_win[2:1]};

    always_comb begin
        count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                count = count + {3'b000, n_win[i]};
            end
        end
    end

    assign col_x = DIM_W'(col_eff);
    assign row_x = DIM_W'(row_eff);

    // Position of the pixel whose window is now complete: one row and one column behind the
    // input. At column zero the window straddles two rows, so the output is the last pixel of
    // the row before, which is on the border and passes through.
    always_comb begin
        if (col_eff == '0) begin
            tr = (row_x >= DIM_W'(2)) ? row_x - DIM_W'(2) : row_x + h_eff - DIM_W'(2);
            tc = w_eff - DIM_W'(1);
        end else begin
            tr = (row_eff == '0) ? h_eff - DIM_W'(1) : row_x - DIM_W'(1);
            tc = col_x - DIM_W'(1);
        end
        interior = (tr >= DIM_W'(1)) && (tr <= h_eff - DIM_W'(2)) &&
                   (tc >= DIM_W'(1)) && (tc <= w_eff - DIM_W'(2));
        if (col_eff == '0) begin
            val_pix = r_win[5];
        end else if (interior) begin
            val_pix = ({1'b0, count} >= {1'b0, r_nbr_thresh});
        end else begin
            val_pix = n_win[4];
        end
        eof_pix = (tr == h_eff - DIM_W'(1)) && (tc == w_eff - DIM_W'(1));
    end

    // Result selection and next state.
    always_comb begin
        k_x    = col_x + DIM_W'(1);
        n_col  = r_col;
        n_row  = r_row;
        n_pend = r_pend;
        emit   = 1'b0;
        if (is_flush) begin
            val_out = pend_full ? r_rd_flush[1] : r_rd_flush[0];
            eof_out = (pend_eff == DIM_W'(1));
        end else begin
            val_out = val_pix;
            eof_out = eof_pix;
        end
        if (in_acc) begin
            if (is_flush) begin
                emit   = flush_ok;
                n_col  = col_eff;
                n_row  = row_eff;
                n_pend = flush_ok ? pend_eff - DIM_W'(1) : pend_eff;
            end else begin
                emit   = pend_full;
                n_pend = pend_full ? pend_eff : pend_eff + DIM_W'(1);
                if (k_x >= w_eff) begin
                    n_col = '0;
                    n_row = (DIM_W'(row_eff) + DIM_W'(1) >= h_eff) ? '0 : row_eff + ROW_W'(1);
                end else begin
                    n_col = k_x[COL_W-1:0];
                    n_row = row_eff;
                end
            end
        end
    end

    // Read addresses look one beat ahead, so the registered read data is ready when the next
    // beat arrives. The flush port fetches the oldest pending border pixel: the upper store's
    // last column when a full row plus one is pending, else the middle store.
    assign mem_we      = in_acc & ~is_flush;
    assign rd_addr_pix = in_acc ? n_col : col_eff;
    assign pend_look   = in_acc ? n_pend : pend_eff;
    assign flush_diff  = (pend_look == w_p1) ? w_eff - DIM_W'(1) : w_eff - pend_look;
    assign rd_addr_flush = flush_diff[COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[col_eff] <= {bit_mid, i_in_data.mask_bit};
        end
        r_rd_pix <= r_line_mem[rd_addr_pix];
        // The last pixel of a frame is written in the same cycle as the first flush read of it.
        if (mem_we && (col_eff == rd_addr_flush)) begin
            r_rd_flush <= {bit_mid, i_in_data.mask_bit};
        end else begin
            r_rd_flush <= r_line_mem[rd_addr_flush];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_nbr_thresh   <= RST_NBR_THRESH;
            r_cfg_hold     <= 1'b1;
        end else begin
            r_cfg_hold <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    CFG_NBR_THRESH:   r_nbr_thresh   <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
            r_win  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_pend <= n_pend;
            if (mem_we) begin
                r_win <= n_win;
            end
        end
    end

    // Output register: it can be refilled in the same cycle that its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data.filtered_bit <= val_out;
            r_out_data.end_of_frame <= eof_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The column counter always stays inside the frame width after a beat.
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_cfg_we |=> DIM_W'(r_col) < $past(w_eff))
        else $error("column counter left the frame after a beat");

    // The pending count never exceeds one row plus one pixel after a beat.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_cfg_we |=> r_pend <= $past(w_p1))
        else $error("pending count above one row plus one");

    // A flush that releases the end of the frame leaves nothing pending.
    a_eof_flush_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_flush && emit && eof_out |=> r_pend == '0)
        else $error("end of frame flushed with pixels still pending");

endmodule
